// File: hdl/zcwc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// zcwc_pkg
// Shared types and constants for the zero-crossing waveform capture block.
// ----------------------------------------------------------------------------
package zcwc_pkg;

    // width of the index and sample fields on the ports
    localparam int unsigned ADDR_W = 8;
    localparam int unsigned DATA_W = 8;

    // raw ADC code to signed: raw minus 128 flips the top bit
    localparam logic [DATA_W-1:0] SIGN_FLIP = 8'h80;
    // previous sample after arm, positive so the first sample is no crossing
    localparam logic [DATA_W-1:0] PREV_ARM  = 8'h7F;
    localparam logic [7:0]        MIN_LEN_RESET = 8'd4;

    typedef enum logic [1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_ARM    = 2'd1,
        MODE_STOP   = 2'd2,
        MODE_READ   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_WAIT      = 3'd1,
        ST_CAPTURING = 3'd2,
        ST_CAPTURED  = 3'd3,
        ST_OVERFLOW  = 3'd4
    } capture_status_t;

    // one access to the sample store, issued with each accepted word
    typedef struct packed {
        logic              take;     // a word is accepted this cycle
        logic              is_read;  // the word is a buffer read
        logic              we;       // store wdata at waddr
        logic              wr_zero;  // also store wdata as entry 0
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } store_req_t;

endpackage : zcwc_pkg
`default_nettype wire

// File: hdl/zcwc_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// zcwc_store
// Sample store: one synchronous RAM with a registered read, per-entry valid
// bits so that unwritten entries read as zero, and entry 0 held in a register
// so a crossing can write its own index and entry 0 in the same cycle.
// ----------------------------------------------------------------------------
module zcwc_store #(
    parameter int unsigned DEPTH = 256
) (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  zcwc_pkg::store_req_t      req,
    output logic [zcwc_pkg::DATA_W-1:0] rd_value
);
    import zcwc_pkg::*;

    localparam int unsigned IW = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [DEPTH-1:0]  valid_next;
    logic [DATA_W-1:0] entry0_reg;
    logic [DATA_W-1:0] entry0_next;
    logic [DATA_W-1:0] mem_q_reg;
    logic              sel_mem_reg;
    logic              sel_mem_next;
    logic [DATA_W-1:0] alt_reg;
    logic [DATA_W-1:0] alt_next;

    logic [IW-1:0] widx;
    logic [IW-1:0] ridx;
    logic          r_in_range;
    logic          r_is_zero;

    assign widx       = req.waddr[IW-1:0];
    assign ridx       = req.raddr[IW-1:0];
    assign r_in_range = (req.raddr <= ADDR_LAST);
    assign r_is_zero  = (req.raddr == '0);

    // RAM write port and registered read port
    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[widx] <= req.wdata;
        end
        if (req.take && req.is_read) begin
            mem_q_reg <= mem[ridx];
        end
    end

    // valid bits, entry 0 and read select
    always_comb begin
        valid_next   = valid_reg;
        entry0_next  = entry0_reg;
        sel_mem_next = sel_mem_reg;
        alt_next     = alt_reg;
        if (req.we) begin
            valid_next[widx] = 1'b1;
            if (req.wr_zero || (req.waddr == '0)) begin
                entry0_next = req.wdata;
            end
        end
        if (req.take) begin
            sel_mem_next = req.is_read && r_in_range && !r_is_zero && valid_reg[ridx];
            alt_next     = (req.is_read && r_is_zero) ? entry0_reg : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            entry0_reg  <= '0;
            sel_mem_reg <= 1'b0;
            alt_reg     <= '0;
        end else begin
            valid_reg   <= valid_next;
            entry0_reg  <= entry0_next;
            sel_mem_reg <= sel_mem_next;
            alt_reg     <= alt_next;
        end
    end

    assign rd_value = sel_mem_reg ? mem_q_reg : alt_reg;

`ifndef ASSERT_OFF
    // a write to entry 0 always lands in the entry 0 register
    a_entry0_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (req.we && (req.waddr == '0)) |=> (entry0_reg == $past(req.wdata)))
        else $error("entry 0 register missed a write");

    // a non-read word always returns zero on the next cycle
    a_nonread_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (req.take && !req.is_read) |=> (rd_value == '0))
        else $error("read value not zero for non-read word");

    // a written entry is marked valid
    a_valid_set: assert property (@(posedge aclk) disable iff (!aresetn)
        req.we |=> valid_reg[$past(widx)])
        else $error("valid bit not set after write");
`endif

endmodule : zcwc_store
`default_nettype wire

// File: hdl/zero_cross_waveform_capture.sv
`default_nettype none
// A result word is registered and is valid in the cycle after its input word is accepted.
// Throughput: one word per cycle unless the master side stalls; the capture
// state and the store read/write both complete in the accepting cycle, and
// a stalled master side holds s_tready low (s_tready = !m_tvalid || m_tready).
// Reset: synchronous, active low; status idle, index zero, min_length 4, and
// the store reads as all zero at once through per-entry valid bits.
// ----------------------------------------------------------------------------
// zero_cross_waveform_capture
// Captures one waveform cycle between rising zero crossings into a sample
// store and serves buffer reads, one result word per input word.
// ----------------------------------------------------------------------------
module zero_cross_waveform_capture #(
    parameter int unsigned BUFFER_DEPTH = 256
) (
    input  wire         aclk,
    input  wire         aresetn,
    // configuration: min_length
    input  wire         cfg_we,
    input  wire  [7:0]  cfg_wdata,
    // input words
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,   // [7:0] sample, [15:8] read_index
    input  wire  [1:0]  s_tuser,   // [1:0] mode
    // result words
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [23:0] m_tdata    // [2:0] status, [10:3] length, [18:11] read_value
);
    import zcwc_pkg::*;

    localparam int unsigned IW = $clog2(BUFFER_DEPTH);
    localparam logic [IW-1:0] IDX_LAST = IW'(BUFFER_DEPTH - 1);

    capture_status_t   status_reg, status_next;
    logic [IW-1:0]     wr_idx_reg, wr_idx_next;
    logic [DATA_W-1:0] prev_reg, prev_next;
    logic [7:0]        min_len_reg;
    logic              out_valid_reg, out_valid_next;
    capture_status_t   out_status_reg, out_status_next;
    logic [7:0]        out_len_reg, out_len_next;

    logic              s_fire;
    mode_t             mode;
    logic [DATA_W-1:0] samp;
    logic              crossing;
    logic              len_ok;
    store_req_t        req;
    logic [DATA_W-1:0] rd_value;

    assign s_tready = !out_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign mode     = mode_t'(s_tuser[1:0]);
    assign samp     = s_tdata[7:0] ^ SIGN_FLIP;
    assign crossing = !samp[DATA_W-1] && prev_reg[DATA_W-1];
    assign len_ok   = (8'(wr_idx_reg) >= min_len_reg);

    // capture control and store request
    always_comb begin
        status_next     = status_reg;
        wr_idx_next     = wr_idx_reg;
        prev_next       = prev_reg;
        req             = '0;
        req.take        = s_fire;
        req.is_read     = (mode == MODE_READ);
        req.waddr       = ADDR_W'(wr_idx_reg);
        req.wdata       = samp;
        req.raddr       = s_tdata[15:8];
        if (s_fire) begin
            unique case (mode)
                MODE_SAMPLE: begin
                    if (status_reg == ST_WAIT) begin
                        req.we    = 1'b1;
                        prev_next = samp;
                        if (crossing) begin
                            req.wr_zero = 1'b1;
                            status_next = ST_CAPTURING;
                            wr_idx_next = IW'(1);
                        end else begin
                            wr_idx_next = (wr_idx_reg == IDX_LAST) ? '0
                                                                   : wr_idx_reg + 1'b1;
                        end
                    end else if (status_reg == ST_CAPTURING) begin
                        req.we    = 1'b1;
                        prev_next = samp;
                        priority if (wr_idx_reg == IDX_LAST) begin
                            status_next = ST_OVERFLOW;
                        end else if (crossing && len_ok) begin
                            status_next = ST_CAPTURED;
                        end else begin
                            wr_idx_next = wr_idx_reg + 1'b1;
                        end
                    end
                end
                MODE_ARM: begin
                    status_next = ST_WAIT;
                    wr_idx_next = '0;
                    prev_next   = PREV_ARM;
                end
                MODE_STOP: begin
                    status_next = ST_IDLE;
                end
                MODE_READ: begin
                end
                default: begin
                end
            endcase
        end
    end

    // output register
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_len_next    = out_len_reg;
        if (s_fire) begin
            out_valid_next  = 1'b1;
            out_status_next = status_next;
            out_len_next    = 8'(wr_idx_next);
        end else if (m_tready) begin
            out_valid_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg     <= ST_IDLE;
            wr_idx_reg     <= '0;
            prev_reg       <= '0;
            min_len_reg    <= MIN_LEN_RESET;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_IDLE;
            out_len_reg    <= '0;
        end else begin
            status_reg     <= status_next;
            wr_idx_reg     <= wr_idx_next;
            prev_reg       <= prev_next;
            if (cfg_we) begin
                min_len_reg <= cfg_wdata;
            end
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_len_reg    <= out_len_next;
        end
    end

    zcwc_store #(
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (req),
        .rd_value (rd_value)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, rd_value, out_len_reg, out_status_reg};

`ifndef ASSERT_OFF
    // overflow is only reached at the last index and stays there
    a_ovf_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (status_reg == ST_OVERFLOW) |-> (wr_idx_reg == IDX_LAST))
        else $error("overflow with index short of the last entry");

    // capture always starts past entry 0
    a_cap_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (status_reg == ST_CAPTURING) |-> (wr_idx_reg != '0))
        else $error("capturing at index zero");

    // samples while idle leave the capture state alone
    a_idle_ignore: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && (mode == MODE_SAMPLE) && (status_reg == ST_IDLE))
        |=> ((status_reg == ST_IDLE) && $stable(wr_idx_reg) && $stable(prev_reg)))
        else $error("sample changed state while idle");

    // the result word reports the state the accepted word left behind
    a_out_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> (m_tvalid && (m_tdata[2:0] == status_reg)
                    && (m_tdata[10:3] == 8'(wr_idx_reg))))
        else $error("result word does not match capture state");
`endif

endmodule : zero_cross_waveform_capture
`default_nettype wire
